FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the task scheduler
// Operation codes, slot states, error codes, controller states and the fixed
// field widths of the ports.
// ----------------------------------------------------------------------------
package pts_pkg;

    // default table size and priority width
    localparam int DEF_MAX_TASKS     = 8;
    localparam int DEF_PRIORITY_BITS = 8;

    // fixed port field widths
    localparam int OP_W       = 3;
    localparam int REQ_PRIO_W = 8;
    localparam int DELAY_W    = 32;
    localparam int TICK_W     = 32;
    localparam int SLOT_OUT_W = 3;
    localparam int ERR_W      = 2;
    localparam int CFG_W      = 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_DELAY     = 3'd1,
        OP_TERMINATE = 3'd2,
        OP_TICK      = 3'd3,
        OP_ENABLE    = 3'd4,
        OP_DISABLE   = 3'd5,
        OP_SCHEDULE  = 3'd6,
        OP_IGNORE    = 3'd7
    } t_op;

    // per-slot task state
    typedef enum logic [1:0] {
        ST_DORMANT = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_PENDING = 2'd3
    } t_slot_state;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_FULL       = 2'd1,
        ERR_NO_CURRENT = 2'd2
    } t_err;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_fsm;

endpackage
`default_nettype wire

FILE: rtl/pts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/priority_task_scheduler_with_delays.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays: fixed-priority preemptive scheduler
// Slot table (state, priority, delay count) held in one RAM; every operation
// is applied by a read-modify-write sweep over the used slots but the idle
// slot 0; with scheduling on, the sweep picks the highest-priority ready task.
// ----------------------------------------------------------------------------
// Usage
//   Input channel i_valid / o_stall carries one operation (i_op,
//   i_priority_req, i_delay_ticks); a transfer happens on a clock edge with
//   i_valid high and o_stall low. Output channel o_valid / i_stall carries one
//   result per operation. i_cfg_we with i_cfg_wdata writes the idle task
//   priority; write it only while the block is idle.
//   Each operation sweeps the slot table, one entry per cycle through the
//   single RAM read port, and its result is registered at the commit.
//   One operation at a time: o_stall is high after the accept until the
//   commit is done, so a new operation is not taken before the last commits.
//   Reset: only the idle task exists, scheduling is off, tick count is zero.
//   The RAM is not cleared: entries at or above the used count are never
//   read, and a create writes its whole entry.
//   Stall: a result waits in the output register while i_stall is high; the
//   next operation is taken meanwhile and held in its commit cycle until the
//   output register is free.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_delays #(
    parameter int MAX_TASKS     = pts_pkg::DEF_MAX_TASKS,
    parameter int PRIORITY_BITS = pts_pkg::DEF_PRIORITY_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [pts_pkg::CFG_W-1:0]       i_cfg_wdata,
    // operation channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [pts_pkg::OP_W-1:0]        i_op,
    input  wire logic [pts_pkg::REQ_PRIO_W-1:0]  i_priority_req,
    input  wire logic [pts_pkg::DELAY_W-1:0]     i_delay_ticks,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [pts_pkg::SLOT_OUT_W-1:0]       o_next_task,
    output logic                                 o_switched,
    output logic [pts_pkg::SLOT_OUT_W-1:0]       o_created_slot,
    output logic [pts_pkg::ERR_W-1:0]            o_error_code,
    output logic [pts_pkg::TICK_W-1:0]           o_tick_count,
    output logic                                 o_sched_on
);

    import pts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef struct packed {
        t_slot_state              st;
        logic [PRIORITY_BITS-1:0] prio;
        logic [DELAY_W-1:0]       dly;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // control state
    t_fsm                     r_state,     n_state;
    logic [CFG_W-1:0]         r_idle_prio, n_idle_prio;
    logic [CW-1:0]            r_used,      n_used;
    logic [IW-1:0]            r_cur,       n_cur;
    logic                     r_cur_valid, n_cur_valid;
    logic                     r_sched_en,  n_sched_en;
    logic [TICK_W-1:0]        r_ticks,     n_ticks;
    logic                     r_pv,        n_pv;
    logic                     r_out_valid, n_out_valid;

    // operation being worked on
    t_op                      r_op,        n_op;
    logic [PRIORITY_BITS-1:0] r_prio,      n_prio;
    logic [DELAY_W-1:0]       r_dly,       n_dly;
    logic                     r_create_ok, n_create_ok;
    logic [IW-1:0]            r_created,   n_created;
    t_err                     r_err,       n_err;
    logic                     r_run,       n_run;
    logic [CW-1:0]            r_bound,     n_bound;
    logic [CW-1:0]            r_rd_idx,    n_rd_idx;
    logic [IW-1:0]            r_pv_idx,    n_pv_idx;
    logic [IW-1:0]            r_best,      n_best;
    logic [PRIORITY_BITS-1:0] r_best_prio, n_best_prio;
    t_entry                   r_best_ent,  n_best_ent;

    // result register
    logic [SLOT_OUT_W-1:0]    r_o_next,    n_o_next;
    logic                     r_o_sw,      n_o_sw;
    logic [SLOT_OUT_W-1:0]    r_o_created, n_o_created;
    t_err                     r_o_err,     n_o_err;
    logic [TICK_W-1:0]        r_o_ticks,   n_o_ticks;
    logic                     r_o_sched,   n_o_sched;

    // ram ports
    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic                     ram_re;
    logic [EW-1:0]            ram_rdata;

    t_entry                   ent_rd;
    t_entry                   ent_new;
    t_entry                   commit_ent;
    logic                     hit_cur;
    logic                     cand;

    pts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent_rd = t_entry'(ram_rdata);

    // per-entry update: the operation first, then the scheduler step
    always_comb begin
        ent_new = ent_rd;
        hit_cur = r_cur_valid && (r_pv_idx == r_cur);
        if (r_op == OP_CREATE && r_create_ok && r_pv_idx == r_created) begin
            ent_new.st   = ST_READY;
            ent_new.prio = r_prio;
            ent_new.dly  = '0;
        end
        if (r_op == OP_DELAY && hit_cur) begin
            ent_new.st  = ST_PENDING;
            ent_new.dly = r_dly;
        end
        if (r_op == OP_TERMINATE && hit_cur) begin
            ent_new.st = ST_DORMANT;
        end
        if (r_op == OP_TICK && ent_new.dly != '0) begin
            ent_new.dly = ent_new.dly - DELAY_W'(1);
            if (ent_new.dly == '0) begin
                ent_new.st = ST_READY;
            end
        end
        if (r_run && hit_cur && ent_new.st == ST_RUNNING) begin
            ent_new.st = ST_READY;
        end
        cand = r_run && (ent_new.st == ST_READY) && (ent_new.prio > r_best_prio);
    end

    // chosen task goes to running at commit
    always_comb begin
        commit_ent    = r_best_ent;
        commit_ent.st = ST_RUNNING;
    end

    // controller: accept, sweep, commit
    always_comb begin
        n_state     = r_state;
        n_idle_prio = i_cfg_we ? i_cfg_wdata : r_idle_prio;
        n_used      = r_used;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_sched_en  = r_sched_en;
        n_ticks     = r_ticks;
        n_pv        = r_pv;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_prio      = r_prio;
        n_dly       = r_dly;
        n_create_ok = r_create_ok;
        n_created   = r_created;
        n_err       = r_err;
        n_run       = r_run;
        n_bound     = r_bound;
        n_rd_idx    = r_rd_idx;
        n_pv_idx    = r_pv_idx;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_best_ent  = r_best_ent;
        n_o_next    = r_o_next;
        n_o_sw      = r_o_sw;
        n_o_created = r_o_created;
        n_o_err     = r_o_err;
        n_o_ticks   = r_o_ticks;
        n_o_sched   = r_o_sched;
        ram_we      = 1'b0;
        ram_waddr   = r_pv_idx;
        ram_wdata   = ent_new;
        ram_re      = 1'b0;

        // result taken by the receiver
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op        = t_op'(i_op);
                    n_prio      = PRIORITY_BITS'(i_priority_req);
                    n_dly       = i_delay_ticks;
                    n_create_ok = (t_op'(i_op) == OP_CREATE) && (r_used < CW'(MAX_TASKS));
                    n_created   = n_create_ok ? r_used[IW-1:0] : '0;
                    n_used      = r_used + CW'(n_create_ok);
                    n_bound     = n_used;
                    n_err       = ERR_NONE;
                    if (t_op'(i_op) == OP_CREATE && !n_create_ok) begin
                        n_err = ERR_FULL;
                    end
                    if ((t_op'(i_op) == OP_DELAY || t_op'(i_op) == OP_TERMINATE)
                        && !r_cur_valid) begin
                        n_err = ERR_NO_CURRENT;
                    end
                    if (t_op'(i_op) == OP_TICK) begin
                        n_ticks = r_ticks + TICK_W'(1);
                    end
                    if (t_op'(i_op) == OP_ENABLE) begin
                        n_sched_en = 1'b1;
                    end
                    if (t_op'(i_op) == OP_DISABLE) begin
                        n_sched_en = 1'b0;
                    end
                    n_run       = n_sched_en && (t_op'(i_op) != OP_IGNORE);
                    n_rd_idx    = CW'(1);
                    n_pv        = 1'b0;
                    n_best      = '0;
                    n_best_prio = PRIORITY_BITS'(r_idle_prio);
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // read slot rd_idx, write back slot pv_idx read in the cycle before
                ram_re   = r_rd_idx < r_bound;
                n_rd_idx = r_rd_idx + CW'(ram_re);
                n_pv     = ram_re;
                n_pv_idx = r_rd_idx[IW-1:0];
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pv_idx;
                    ram_wdata = ent_new;
                    if (cand) begin
                        n_best      = r_pv_idx;
                        n_best_prio = ent_new.prio;
                        n_best_ent  = ent_new;
                    end
                end
                if (!ram_re) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!r_out_valid || !i_stall) begin
                    if (r_run) begin
                        n_cur       = r_best;
                        n_cur_valid = 1'b1;
                        if (r_best != '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_best;
                            ram_wdata = commit_ent;
                        end
                        n_o_next = SLOT_OUT_W'(r_best);
                    end else begin
                        n_o_next = r_cur_valid ? SLOT_OUT_W'(r_cur) : '0;
                    end
                    n_o_sw      = r_run;
                    n_o_created = SLOT_OUT_W'(r_created);
                    n_o_err     = r_err;
                    n_o_ticks   = r_ticks;
                    n_o_sched   = r_sched_en;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle_prio <= '0;
            r_used      <= CW'(1);
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_sched_en  <= 1'b0;
            r_ticks     <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idle_prio <= n_idle_prio;
            r_used      <= n_used;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_sched_en  <= n_sched_en;
            r_ticks     <= n_ticks;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_prio      <= n_prio;
        r_dly       <= n_dly;
        r_create_ok <= n_create_ok;
        r_created   <= n_created;
        r_err       <= n_err;
        r_run       <= n_run;
        r_bound     <= n_bound;
        r_rd_idx    <= n_rd_idx;
        r_pv_idx    <= n_pv_idx;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_best_ent  <= n_best_ent;
        r_o_next    <= n_o_next;
        r_o_sw      <= n_o_sw;
        r_o_created <= n_o_created;
        r_o_err     <= n_o_err;
        r_o_ticks   <= n_o_ticks;
        r_o_sched   <= n_o_sched;
    end

    // ports
    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_next_task    = r_o_next;
    assign o_switched     = r_o_sw;
    assign o_created_slot = r_o_created;
    assign o_error_code   = r_o_err;
    assign o_tick_count   = r_o_ticks;
    assign o_sched_on     = r_o_sched;

endmodule
`default_nettype wire

FILE: rtl/pts_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_chk: port-level checks of the task scheduler
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pts_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [pts_pkg::SLOT_OUT_W-1:0]  o_next_task,
    input wire logic                            o_switched,
    input wire logic [pts_pkg::SLOT_OUT_W-1:0]  o_created_slot,
    input wire logic [pts_pkg::ERR_W-1:0]       o_error_code,
    input wire logic [pts_pkg::TICK_W-1:0]      o_tick_count,
    input wire logic                            o_sched_on
);

    import pts_pkg::*;

    logic              r_seen, n_seen;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic              out_xfer;

    assign out_xfer = o_valid && !i_stall;

    // tick count of the last result transfer
    always_comb begin
        n_seen  = r_seen;
        n_ticks = r_ticks;
        if (out_xfer) begin
            n_seen  = 1'b1;
            n_ticks = o_tick_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_ticks <= '0;
        end else begin
            r_seen  <= n_seen;
            r_ticks <= n_ticks;
        end
    end

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_next_task, o_switched,
            o_created_slot, o_error_code, o_tick_count, o_sched_on}))
        else $error("result changed while stalled");

    // one operation at a time: busy right after an input transfer
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while previous operation in flight");

    // a context switch needs scheduling on
    a_switch_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_switched |-> o_sched_on)
        else $error("switch reported with scheduling off");

    // an error never comes with a created slot
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_NONE |-> o_created_slot == '0)
        else $error("created slot reported with an error");

    // tick count moves by at most one between results
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen |->
            (o_tick_count == r_ticks || o_tick_count == r_ticks + TICK_W'(1)))
        else $error("tick count jumped");

endmodule

bind priority_task_scheduler_with_delays pts_chk u_pts_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_next_task    (o_next_task),
    .o_switched     (o_switched),
    .o_created_slot (o_created_slot),
    .o_error_code   (o_error_code),
    .o_tick_count   (o_tick_count),
    .o_sched_on     (o_sched_on)
);
`default_nettype wire

FILE: tb/tb_priority_task_scheduler_with_delays.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler_with_delays: self-checking scheduler testbench
// Operations go in over the valid/stall channel. A behavioural copy of the
// slot table predicts each result, and results are checked in order, field
// by field. Directed cases run first, then random traffic under several
// idle task priorities; random idling on both channels bar the first batch.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler_with_delays;
    import pts_pkg::*;

    localparam int NUM_SLOTS     = DEF_MAX_TASKS;
    localparam int HALF_PERIOD   = 5;
    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PCT      = 24;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] next_task;
        logic                  switched;
        logic [SLOT_OUT_W-1:0] created_slot;
        t_err                  error_code;
        logic [TICK_W-1:0]     tick_count;
        logic                  sched_on;
    } t_sched_result;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  i_valid;
    logic                  o_stall;
    logic [OP_W-1:0]       i_op;
    logic [REQ_PRIO_W-1:0] i_priority_req;
    logic [DELAY_W-1:0]    i_delay_ticks;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [SLOT_OUT_W-1:0] o_next_task;
    logic                  o_switched;
    logic [SLOT_OUT_W-1:0] o_created_slot;
    logic [ERR_W-1:0]      o_error_code;
    logic [TICK_W-1:0]     o_tick_count;
    logic                  o_sched_on;

    // predicted slot table and scheduler state
    t_slot_state           slot_st   [NUM_SLOTS];
    logic [7:0]            slot_pri  [NUM_SLOTS];
    logic [31:0]           slot_wait [NUM_SLOTS];
    int                    used_slots;
    logic [2:0]            run_slot;
    logic                  run_valid;
    logic                  sched_en;
    logic [31:0]           tick_ctr;
    logic [7:0]            idle_pri;

    t_sched_result         dispatch_q [$];
    int                    mismatches = 0;
    bit                    calm = 1'b0;

    priority_task_scheduler_with_delays u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .i_delay_ticks  (i_delay_ticks),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_task    (o_next_task),
        .o_switched     (o_switched),
        .o_created_slot (o_created_slot),
        .o_error_code   (o_error_code),
        .o_tick_count   (o_tick_count),
        .o_sched_on     (o_sched_on)
    );

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // table state after reset
    task automatic clear_table();
        int i;
        for (i = 0; i < NUM_SLOTS; i++) begin
            slot_st[i]   = ST_DORMANT;
            slot_pri[i]  = '0;
            slot_wait[i] = '0;
        end
        slot_st[0] = ST_READY;
        used_slots = 1;
        run_slot   = '0;
        run_valid  = 1'b0;
        sched_en   = 1'b0;
        tick_ctr   = '0;
        idle_pri   = '0;
    endtask

    // running task back to ready, then first strictly highest ready slot wins
    function automatic void reschedule();
        int         i;
        logic [2:0] best;
        logic [7:0] best_pri;
        if (run_valid && slot_st[run_slot] == ST_RUNNING)
            slot_st[run_slot] = ST_READY;
        best     = '0;
        best_pri = idle_pri;
        for (i = 1; i < used_slots; i++) begin
            if (slot_st[i] == ST_READY && slot_pri[i] > best_pri) begin
                best     = i[2:0];
                best_pri = slot_pri[i];
            end
        end
        slot_st[best] = ST_RUNNING;
        run_slot      = best;
        run_valid     = 1'b1;
    endfunction

    // apply one operation to the predicted table and return its result
    function automatic t_sched_result apply_sched_op(t_op op, logic [7:0] prio,
                                                     logic [31:0] dly);
        t_sched_result res;
        int            i;
        res = '0;
        res.error_code = ERR_NONE;
        if (op != OP_IGNORE) begin
            case (op)
                OP_CREATE: begin
                    if (used_slots >= NUM_SLOTS) begin
                        res.error_code = ERR_FULL;
                    end else begin
                        res.created_slot      = used_slots[2:0];
                        slot_st[used_slots]   = ST_READY;
                        slot_pri[used_slots]  = prio;
                        slot_wait[used_slots] = '0;
                        used_slots++;
                    end
                end
                OP_DELAY: begin
                    if (!run_valid) begin
                        res.error_code = ERR_NO_CURRENT;
                    end else begin
                        slot_wait[run_slot] = dly;
                        slot_st[run_slot]   = ST_PENDING;
                    end
                end
                OP_TERMINATE: begin
                    if (!run_valid)
                        res.error_code = ERR_NO_CURRENT;
                    else
                        slot_st[run_slot] = ST_DORMANT;
                end
                OP_TICK: begin
                    tick_ctr = tick_ctr + 1;
                    for (i = 1; i < used_slots; i++) begin
                        if (slot_wait[i] != 0) begin
                            slot_wait[i] = slot_wait[i] - 1;
                            if (slot_wait[i] == 0)
                                slot_st[i] = ST_READY;
                        end
                    end
                end
                OP_ENABLE:  sched_en = 1'b1;
                OP_DISABLE: sched_en = 1'b0;
                default: ;
            endcase
            if (sched_en) begin
                reschedule();
                res.switched = 1'b1;
            end
        end
        res.next_task  = run_valid ? run_slot : 3'd0;
        res.tick_count = tick_ctr;
        res.sched_on   = sched_en;
        return res;
    endfunction

    // one operation transfer, with random gaps ahead of it unless calm is set
    task automatic send_op(t_op op, logic [7:0] prio, logic [31:0] dly);
        @(negedge i_clk);
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_priority_req <= prio;
        i_delay_ticks  <= dly;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        dispatch_q.push_back(apply_sched_op(op, prio, dly));
    endtask

    // stop sending and wait until every result is back and the block settles
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (dispatch_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // idle task priority, written only while the block is quiet
    task automatic write_idle_priority(logic [7:0] level);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= level;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        idle_pri     = level;
    endtask

    // delay amounts: mostly short, a few zero or huge
    function automatic logic [31:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 75)
            return $urandom_range(4, 1);
        else if (r < 92)
            return $urandom_range(20, 5);
        return $urandom;
    endfunction

    // one random operation; tasks are only lost for good when allowed
    task automatic send_random_op(bit allow_kill);
        int unsigned r;
        t_op         op;
        logic [7:0]  prio;
        logic [31:0] dly;
        r    = $urandom_range(99);
        prio = 8'($urandom);
        dly  = pick_delay();
        if (r < 35)      op = OP_TICK;
        else if (r < 57) op = OP_DELAY;
        else if (r < 67) op = OP_SCHEDULE;
        else if (r < 75) op = OP_ENABLE;
        else if (r < 80) op = OP_DISABLE;
        else if (r < 87) op = OP_CREATE;
        else if (r < 96) op = OP_TERMINATE;
        else             op = OP_IGNORE;
        if (!allow_kill && run_valid && run_slot != 0 &&
            (op == OP_TERMINATE || (op == OP_DELAY && (dly == 0 || dly > 1000))))
            op = OP_TICK;
        send_op(op, prio, dly);
    endtask

    // delay and terminate with no current task, ignored opcode, disabled ops
    task automatic test_no_current_task();
        send_op(OP_DELAY, 8'h00, 32'hFFFF_FFFF);
        send_op(OP_TERMINATE, 8'hFF, 32'h0000_0000);
        send_op(OP_IGNORE, 8'h5A, 32'hA5A5_A5A5);
        send_op(OP_TICK, 8'h00, 32'h0);
        send_op(OP_SCHEDULE, 8'h00, 32'h0);
    endtask

    // idle is chosen even when pending forever or terminated
    task automatic test_idle_fallback();
        send_op(OP_ENABLE, 8'h00, 32'h0);
        send_op(OP_DELAY, 8'h00, 32'h0);
        send_op(OP_SCHEDULE, 8'h00, 32'h0);
        send_op(OP_TERMINATE, 8'h00, 32'h0);
        send_op(OP_TICK, 8'h00, 32'h0);
    endtask

    // fill every slot with priority extremes and ties, then overflow
    task automatic test_fill_table();
        send_op(OP_CREATE, 8'hFF, 32'h0);
        send_op(OP_CREATE, 8'h00, 32'h0);
        send_op(OP_CREATE, 8'h80, 32'h0);
        send_op(OP_CREATE, 8'h01, 32'h0);
        send_op(OP_CREATE, 8'h7F, 32'h0);
        send_op(OP_CREATE, 8'hFF, 32'h0);
        send_op(OP_CREATE, 8'h55, 32'h0);
        send_op(OP_CREATE, 8'hAA, 32'h0);
    endtask

    // delayed task wakes on its count and wins the tie by slot order
    task automatic test_delay_wakeup();
        send_op(OP_DELAY, 8'h00, 32'd2);
        send_op(OP_TICK, 8'h00, 32'h0);
        send_op(OP_TICK, 8'h00, 32'h0);
    endtask

    // no switching while disabled, wake-up still applied
    task automatic test_disabled_hold();
        send_op(OP_DISABLE, 8'h00, 32'h0);
        send_op(OP_DELAY, 8'h00, 32'd1);
        send_op(OP_TICK, 8'h00, 32'h0);
        send_op(OP_IGNORE, 8'h00, 32'h0);
        send_op(OP_SCHEDULE, 8'h00, 32'h0);
        send_op(OP_ENABLE, 8'h00, 32'h0);
    endtask

    // random traffic under one idle priority
    task automatic test_random_traffic(logic [7:0] level, int count, bit allow_kill,
                                       bit steady);
        int n;
        drain();
        write_idle_priority(level);
        calm = steady;
        for (n = 0; n < count; n++)
            send_random_op(allow_kill);
        calm = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.next_task    = o_next_task;
            got.switched     = o_switched;
            got.created_slot = o_created_slot;
            got.error_code   = t_err'(o_error_code);
            got.tick_count   = o_tick_count;
            got.sched_on     = o_sched_on;
            if (dispatch_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: next=%0d sw=%0b",
                             got.next_task, got.switched);
            end else begin
                want = dispatch_q.pop_front();
                if (got.next_task != want.next_task || got.switched != want.switched ||
                    got.created_slot != want.created_slot ||
                    got.error_code != want.error_code ||
                    got.tick_count != want.tick_count || got.sched_on != want.sched_on) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("expected next=%0d sw=%0b slot=%0d err=%0d ticks=%0d on=%0b",
                                 want.next_task, want.switched, want.created_slot,
                                 want.error_code, want.tick_count, want.sched_on);
                        $display("actual   next=%0d sw=%0b slot=%0d err=%0d ticks=%0d on=%0b",
                                 got.next_task, got.switched, got.created_slot,
                                 got.error_code, got.tick_count, got.sched_on);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // test sequence
    initial begin
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_valid        <= 1'b0;
        i_op           <= OP_IGNORE;
        i_priority_req <= '0;
        i_delay_ticks  <= '0;
        clear_table();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_idle_priority(8'h00);

        test_no_current_task();
        test_idle_fallback();
        test_fill_table();
        test_delay_wakeup();
        test_disabled_hold();

        test_random_traffic(8'hFF, 225, 1'b0, 1'b1);
        test_random_traffic(8'h80, 225, 1'b0, 1'b0);
        test_random_traffic(8'($urandom), 225, 1'b0, 1'b0);
        test_random_traffic(8'h00, 225, 1'b0, 1'b0);
        test_random_traffic(8'h40, 225, 1'b1, 1'b0);

        drain();
        if (mismatches == 0 && dispatch_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/priority_task_scheduler_with_delays.sv
rtl/pts_chk.sv
tb/tb_priority_task_scheduler_with_delays.sv
